/* rtl/assert_macros.svh */
// assertion macros used by the top level rtl file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// assert that a implies b at the next edge
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("assertion failed");
// assert that a implies b in the same edge
`define ASSERT_SAME(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("assertion failed");
`endif

/* rtl/salc_pkg.sv */
// package of the lru cache tag tracker: sizes, register indexes, queue entry type
// no dependencies
`default_nettype none
package salc_pkg;
  localparam int MAX_SET_BITS_DEF = 6;
  localparam int MAX_WAYS_DEF = 8;
  localparam logic [1:0] REG_SET_BITS = 2'd0;
  localparam logic [1:0] REG_WAYS = 2'd1;
  localparam logic [1:0] REG_BLOCK_BITS = 2'd2;
  localparam int CFG_W = 6;

  // one access handed from front to back
  typedef struct packed {
    logic [11:0] set;
    logic [63:0] tag;
    logic        last;
  } acc_t;
endpackage
`default_nettype wire

/* rtl/set_assoc_lru_cache_tracker.sv */
// top level of the lru cache tag tracker: config registers, front, queue, back
// depends on salc_pkg, salc_front, salc_queue, salc_back, assert_macros.svh
//
// usage:
//   in_* is the item channel (tuser = kind, tdata = address), out_* gives one
//   result per access (tlast marks the final result of an item), cfg_* writes
//   registers 0 set_bits, 1 ways_in_use, 2 block_bits; write only while idle.
//   an access passes the front, the queue and the back part's read and write
//   phases into the result register; the second result of a modify follows
//   the first. the back part takes no new access until it has read then
//   written back the last one's row in the tag and age memories.
//   reset clears counters and config, then a clearing pass resets the valid
//   bits one set per cycle; the back part takes no access until it ends. a
//   stalled receiver holds the result register, the back part stops and the
//   queue then fills and stalls the input.
`default_nettype none
`include "assert_macros.svh"
module set_assoc_lru_cache_tracker #(
  parameter int MAX_SET_BITS = salc_pkg::MAX_SET_BITS_DEF,
  parameter int MAX_WAYS = salc_pkg::MAX_WAYS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [63:0] in_tdata,   // address
  input  wire logic        in_tuser,   // kind
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [103:0]     out_tdata,  // hit, miss, evicted, hits_total, misses_total, evictions_total
  output logic             out_tlast,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [salc_pkg::CFG_W-1:0] cfg_data
);
  import salc_pkg::*;
  logic [2:0] sb_r;
  logic [3:0] ways_r;
  logic [5:0] bb_r;
  logic       fv, fr, bv, br;
  acc_t       fa, ba;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sb_r <= 3'd0; ways_r <= 4'd1; bb_r <= 6'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SET_BITS:   sb_r <= cfg_data[2:0];
        REG_WAYS:       ways_r <= cfg_data[3:0];
        REG_BLOCK_BITS: bb_r <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  salc_front #(.MAX_SET_BITS(MAX_SET_BITS)) u_front (
    .clk, .rst_n, .set_bits(sb_r), .block_bits(bb_r),
    .in_valid(in_tvalid), .in_ready(in_tready), .in_kind(in_tuser),
    .in_address(in_tdata), .acc_valid(fv), .acc_ready(fr), .acc(fa));

  salc_queue u_queue (
    .clk, .rst_n, .wr_valid(fv), .wr_ready(fr), .wr_data(fa),
    .rd_valid(bv), .rd_ready(br), .rd_data(ba));

  salc_back #(.MAX_SET_BITS(MAX_SET_BITS), .MAX_WAYS(MAX_WAYS)) u_back (
    .clk, .rst_n, .ways_in_use(ways_r), .acc_valid(bv), .acc_ready(br), .acc(ba),
    .out_tvalid, .out_tready, .out_tdata, .out_tlast);

  `ASSERT_SAME(a_hit_miss_excl, clk, rst_n, out_tvalid, out_tdata[0] != out_tdata[1])
  `ASSERT_SAME(a_evict_is_miss, clk, rst_n, out_tvalid && out_tdata[2], out_tdata[1])
  `ASSERT_NEXT(a_no_accept_busy, clk, rst_n, in_tvalid && in_tready, !in_tready)
endmodule
`default_nettype wire

/* rtl/salc_front.sv */
// front part: accepts items, splits addresses, expands modify into two accesses
// depends on salc_pkg
`default_nettype none
module salc_front #(
  parameter int MAX_SET_BITS = salc_pkg::MAX_SET_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic [2:0]  set_bits,
  input  wire logic [5:0]  block_bits,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_kind,
  input  wire logic [63:0] in_address,
  output logic             acc_valid,
  input  wire logic        acc_ready,
  output salc_pkg::acc_t   acc
);
  import salc_pkg::*;
  localparam int SB_W = (MAX_SET_BITS < 1) ? 1 : MAX_SET_BITS;

  logic        busy_r, busy_nxt;
  logic        second_r, second_nxt;
  logic [63:0] addr_r;
  logic [6:0]  sb, tsh;
  logic [63:0] sh_addr;
  logic [63:0] set_full;

  // hold item until its accesses are queued
  assign in_ready = !busy_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      second_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      second_r <= second_nxt;
    end
    if (in_valid && in_ready) begin
      addr_r <= in_address;
    end
  end

  always_comb begin
    busy_nxt = busy_r;
    second_nxt = second_r;
    if (in_valid && in_ready) begin
      busy_nxt = 1'b1;
      second_nxt = in_kind;
    end else if (acc_valid && acc_ready) begin
      if (second_r) second_nxt = 1'b0;
      else busy_nxt = 1'b0;
    end
  end

  // address split
  always_comb begin
    sb = ({4'd0, set_bits} > 7'(MAX_SET_BITS)) ? 7'(MAX_SET_BITS) : {4'd0, set_bits};
    tsh = sb + {1'b0, block_bits};
    sh_addr = addr_r >> block_bits;
    set_full = sh_addr & ((64'd1 << sb) - 64'd1);
    acc = '0;
    acc.set = 12'(set_full[SB_W-1:0]);
    if (MAX_SET_BITS == 0) acc.set = '0;
    acc.tag = (tsh >= 7'd64) ? 64'd0 : (addr_r >> tsh);
    acc.last = !second_r;
  end
  assign acc_valid = busy_r;
endmodule
`default_nettype wire

/* rtl/salc_queue.sv */
// two-entry queue of accesses between front and back
// depends on salc_pkg
`default_nettype none
module salc_queue (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      wr_valid,
  output logic           wr_ready,
  input  salc_pkg::acc_t wr_data,
  output logic           rd_valid,
  input  wire logic      rd_ready,
  output salc_pkg::acc_t rd_data
);
  import salc_pkg::*;
  acc_t       mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       wr, rd;

  assign wr_ready = cnt_r != 2'd2;
  assign rd_valid = cnt_r != 2'd0;
  assign rd_data = mem_r[rp_r];
  assign wr = wr_valid && wr_ready;
  assign rd = rd_valid && rd_ready;

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (wr) wp_r <= !wp_r;
      if (rd) rp_r <= !rp_r;
      cnt_r <= cnt_r + {1'b0, wr} - {1'b0, rd};
    end
    if (wr) mem_r[wp_r] <= wr_data;
  end
endmodule
`default_nettype wire

/* rtl/salc_back.sv */
// back part: set memory read, lru lookup and update, counters, output register
// depends on salc_pkg
`default_nettype none
module salc_back #(
  parameter int MAX_SET_BITS = salc_pkg::MAX_SET_BITS_DEF,
  parameter int MAX_WAYS = salc_pkg::MAX_WAYS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic [3:0]  ways_in_use,
  input  wire logic        acc_valid,
  output logic             acc_ready,
  input  salc_pkg::acc_t   acc,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [103:0]     out_tdata,
  output logic             out_tlast
);
  import salc_pkg::*;
  localparam int NSETS = 1 << MAX_SET_BITS;
  localparam int SI_W = (MAX_SET_BITS < 1) ? 1 : MAX_SET_BITS;
  localparam int WI_W = (MAX_WAYS < 2) ? 1 : $clog2(MAX_WAYS);
  localparam int RW = (MAX_WAYS < 2) ? 1 : $clog2(MAX_WAYS);
  localparam int CW = $clog2(MAX_WAYS + 1);

  typedef logic [MAX_WAYS-1:0][63:0] tags_t;
  typedef logic [MAX_WAYS-1:0][RW-1:0] recs_t;

  // set-wide memories, one row per set
  tags_t               tag_mem [NSETS];
  recs_t               rec_mem [NSETS];
  logic [MAX_WAYS-1:0] val_r [NSETS];

  logic                phase_r;
  logic                clr_r;
  logic [SI_W-1:0]     clr_idx_r;
  tags_t               tags_q;
  recs_t               recs_q;
  logic [MAX_WAYS-1:0] vals_q;
  acc_t                cur_r;
  logic [31:0]         hc_r, mc_r, ec_r;
  logic                ov_r;
  logic [SI_W-1:0]     si, ci;

  assign si = acc.set[SI_W-1:0];
  assign ci = cur_r.set[SI_W-1:0];
  // phase 0 reads the row, phase 1 writes it back; nothing taken while clearing
  assign acc_ready = !clr_r && !phase_r && (!ov_r || out_tready);

  logic [CW-1:0]       ways;
  logic                hit, placed;
  logic [WI_W-1:0]     way, hw, fw, vw;
  logic [RW-1:0]       lim, vr;
  recs_t               recs_n;
  tags_t               tags_n;
  logic [MAX_WAYS-1:0] vals_n;
  logic                do_all;

  // lookup and lru update for the held row
  always_comb begin
    ways = (ways_in_use == 4'd0) ? CW'(1) :
           ((32'(ways_in_use) > MAX_WAYS) ? CW'(MAX_WAYS) : CW'(ways_in_use));
    hit = 1'b0; hw = '0; placed = 1'b0; fw = '0; vw = '0; vr = recs_q[0];
    for (int w = MAX_WAYS - 1; w >= 0; w--) begin
      if (w < 32'(ways) && vals_q[w] && tags_q[w] == cur_r.tag) begin
        hit = 1'b1; hw = WI_W'(w);
      end
      if (w < 32'(ways) && !vals_q[w]) begin
        placed = 1'b1; fw = WI_W'(w);
      end
    end
    for (int w = 1; w < MAX_WAYS; w++) begin
      if (w < 32'(ways) && recs_q[w] > vr) begin
        vr = recs_q[w]; vw = WI_W'(w);
      end
    end
    way = hit ? hw : (placed ? fw : vw);
    do_all = !hit && placed;
    lim = hit ? recs_q[hw] : vr;
    recs_n = recs_q; tags_n = tags_q; vals_n = vals_q;
    for (int w = 0; w < MAX_WAYS; w++) begin
      if (vals_q[w] && (do_all || recs_q[w] < lim)) recs_n[w] = recs_q[w] + RW'(1);
    end
    recs_n[way] = '0;
    if (!hit) begin
      tags_n[way] = cur_r.tag;
      vals_n[way] = 1'b1;
    end
  end

  logic ev;
  assign ev = !hit && !placed;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= 1'b0;
      ov_r <= 1'b0;
      hc_r <= '0; mc_r <= '0; ec_r <= '0;
      clr_r <= 1'b1;
      clr_idx_r <= '0;
    end else begin
      // clearing pass over the valid rows, one set per cycle
      if (clr_r) begin
        val_r[clr_idx_r] <= '0;
        clr_idx_r <= clr_idx_r + SI_W'(1);
        if (clr_idx_r == SI_W'(NSETS - 1)) clr_r <= 1'b0;
      end
      if (out_tvalid && out_tready) ov_r <= 1'b0;
      if (acc_valid && acc_ready) begin
        phase_r <= 1'b1;
        vals_q <= val_r[si];
      end else if (phase_r) begin
        phase_r <= 1'b0;
        val_r[ci] <= vals_n;
        ov_r <= 1'b1;
        if (hit && hc_r != '1) hc_r <= hc_r + 32'd1;
        if (!hit && mc_r != '1) mc_r <= mc_r + 32'd1;
        if (ev && ec_r != '1) ec_r <= ec_r + 32'd1;
      end
    end
    // payload
    if (acc_valid && acc_ready) begin
      cur_r <= acc;
      tags_q <= tag_mem[si];
      recs_q <= rec_mem[si];
    end
    if (phase_r) begin
      tag_mem[ci] <= tags_n;
      rec_mem[ci] <= recs_n;
      out_tlast <= cur_r.last;
      out_tdata <= {5'd0,
                    (ev && ec_r != '1) ? ec_r + 32'd1 : ec_r,
                    (!hit && mc_r != '1) ? mc_r + 32'd1 : mc_r,
                    (hit && hc_r != '1) ? hc_r + 32'd1 : hc_r,
                    ev, !hit, hit};
    end
  end
  assign out_tvalid = ov_r;
endmodule
`default_nettype wire

/* test/tb_top.sv */
// testbench of the lru cache tag tracker: directed and random items, scoreboard check
// depends on salc_pkg and set_assoc_lru_cache_tracker
`default_nettype none
module tb_top;
  import salc_pkg::*;

  localparam int NSETS = 1 << MAX_SET_BITS_DEF;
  localparam int NWAYS = MAX_WAYS_DEF;
  localparam int WATCHDOG = 20000;

  typedef struct {
    logic        hit;
    logic        miss;
    logic        evicted;
    logic [31:0] hits;
    logic [31:0] misses;
    logic [31:0] evicts;
    logic        last;
  } access_res_t;

  // scoreboard: tag store model and queue of expected access results
  class lru_scoreboard;
    logic [2:0]  set_bits;
    logic [3:0]  ways_cfg;
    logic [5:0]  block_bits;
    bit          valid [NSETS*NWAYS];
    logic [63:0] tags [NSETS*NWAYS];
    int          age [NSETS*NWAYS];
    logic [31:0] hits, misses, evicts;
    access_res_t pending[$];
    int          errors;

    function void clear();
      set_bits = 0; ways_cfg = 1; block_bits = 0;
      foreach (valid[i]) begin valid[i] = 0; tags[i] = 0; age[i] = 0; end
      hits = 0; misses = 0; evicts = 0; errors = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [5:0] val);
      if (idx == REG_SET_BITS) set_bits = val[2:0];
      else if (idx == REG_WAYS) ways_cfg = val[3:0];
      else if (idx == REG_BLOCK_BITS) block_bits = val;
    endfunction

    function void age_below(int base, int lim);
      for (int w = 0; w < NWAYS; w++)
        if (valid[base+w] && age[base+w] < lim) age[base+w]++;
    endfunction

    function void lookup(logic [63:0] addr, logic last);
      int sb, ways, bb, set, base, victim;
      logic [63:0] tag;
      access_res_t r;
      bit hit, placed;
      sb = set_bits > MAX_SET_BITS_DEF ? MAX_SET_BITS_DEF : set_bits;
      ways = ways_cfg == 0 ? 1 : (ways_cfg > NWAYS ? NWAYS : ways_cfg);
      bb = block_bits;
      set = (sb == 0) ? 0 : int'((addr >> bb) & ((64'd1 << sb) - 1));
      tag = (bb + sb >= 64) ? 64'd0 : (addr >> (bb + sb));
      base = set * NWAYS;
      hit = 0; placed = 0;
      r.evicted = 0;
      for (int w = 0; w < ways; w++)
        if (!hit && valid[base+w] && tags[base+w] == tag) begin
          age_below(base, age[base+w]);
          age[base+w] = 0;
          hit = 1;
        end
      if (hit) begin
        if (hits != '1) hits++;
      end else begin
        if (misses != '1) misses++;
        for (int w = 0; w < ways; w++)
          if (!placed && !valid[base+w]) begin
            age_below(base, 255);
            valid[base+w] = 1; tags[base+w] = tag; age[base+w] = 0;
            placed = 1;
          end
        if (!placed) begin
          victim = 0;
          for (int w = 1; w < ways; w++)
            if (age[base+w] > age[base+victim]) victim = w;
          age_below(base, age[base+victim]);
          tags[base+victim] = tag; age[base+victim] = 0;
          r.evicted = 1;
          if (evicts != '1) evicts++;
        end
      end
      r.hit = hit; r.miss = !hit;
      r.hits = hits; r.misses = misses; r.evicts = evicts; r.last = last;
      pending.push_back(r);
    endfunction

    function void note_item(logic kind, logic [63:0] addr);
      if (kind) begin lookup(addr, 0); lookup(addr, 1); end
      else lookup(addr, 1);
    endfunction

    function void check_result(logic [103:0] d, logic last);
      access_res_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %h last %b", $time, d, last);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (d[0] !== e.hit) begin
        $display("%0t: hit exp %b got %b", $time, e.hit, d[0]); errors++;
      end
      if (d[1] !== e.miss) begin
        $display("%0t: miss exp %b got %b", $time, e.miss, d[1]); errors++;
      end
      if (d[2] !== e.evicted) begin
        $display("%0t: evicted exp %b got %b", $time, e.evicted, d[2]); errors++;
      end
      if (d[34:3] !== e.hits) begin
        $display("%0t: hits_total exp %0d got %0d", $time, e.hits, d[34:3]); errors++;
      end
      if (d[66:35] !== e.misses) begin
        $display("%0t: misses_total exp %0d got %0d", $time, e.misses, d[66:35]);
        errors++;
      end
      if (d[98:67] !== e.evicts) begin
        $display("%0t: evictions_total exp %0d got %0d", $time, e.evicts, d[98:67]);
        errors++;
      end
      if (last !== e.last) begin
        $display("%0t: last exp %b got %b", $time, e.last, last); errors++;
      end
    endfunction
  endclass

  logic         clk = 0;
  logic         rst_n = 0;
  logic         in_tvalid = 0;
  logic         in_tready;
  logic [63:0]  in_tdata = 0;   // address
  logic         in_tuser = 0;   // kind
  logic         out_tvalid;
  logic         out_tready = 0;
  logic [103:0] out_tdata;      // hit, miss, evicted, hits_total, misses_total, evictions_total
  logic         out_tlast;
  logic         cfg_we = 0;
  logic [1:0]   cfg_index = 0;
  logic [CFG_W-1:0] cfg_data = 0;

  lru_scoreboard sb;
  bit   hold_off = 0;
  int   idle_cycles = 0;
  logic [63:0] addr_pool [16];

  set_assoc_lru_cache_tracker DUT (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // short gaps mostly, a long one now and then
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // receiver side with random back pressure
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata, out_tlast);
  end

  initial begin
    int g;
    @(posedge clk);
    forever begin
      if (hold_off) begin
        out_tready <= 0;
        repeat (300) @(posedge clk);
        hold_off = 0;
      end
      g = gap_len();
      out_tready <= (g == 0);
      @(posedge clk);
      if (g != 0) begin
        repeat (g - 1) @(posedge clk);
        out_tready <= 1;
        @(posedge clk);
      end
    end
  end

  // watchdog on cycles with no handshake
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  task automatic send_item(logic kind, logic [63:0] addr, bit use_gap);
    int g;
    g = use_gap ? gap_len() : 0;
    if (g > 0) begin
      in_tvalid <= 0;
      repeat (g) @(posedge clk);
    end
    in_tvalid <= 1;
    in_tuser <= kind;
    in_tdata <= addr;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_item(kind, addr);
  endtask

  task automatic drain();
    in_tvalid <= 0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_cfg(logic [1:0] idx, logic [5:0] val);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 0;
    sb.write_reg(idx, val);
  endtask

  task automatic set_config(int sbits, int ways, int bbits);
    drain();
    write_cfg(REG_SET_BITS, 6'(sbits));
    write_cfg(REG_WAYS, 6'(ways));
    write_cfg(REG_BLOCK_BITS, 6'(bbits));
  endtask

  // random address from a small pool so that sets hit and thrash
  function automatic logic [63:0] pick_addr();
    logic [63:0] a;
    if ($urandom_range(0, 9) == 0) a = {$urandom, $urandom};
    else begin
      a = addr_pool[$urandom_range(0, 15)];
      a[3:0] = 4'($urandom);
    end
    return a;
  endfunction

  initial begin
    sb = new();
    sb.clear();
    repeat (12) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: reset config, extremes of address and kind
    send_item(0, 64'd0, 0);
    send_item(0, 64'd0, 0);
    send_item(1, '1, 0);
    send_item(1, 64'h8000_0000_0000_0000, 0);
    send_item(0, 64'h1, 0);
    // four ways in use, lru eviction order within one set
    set_config(2, 4, 4);
    for (int i = 0; i < 6; i++) send_item(0, 64'(i) << 6, 0);
    send_item(0, 64'h40, 0);
    send_item(1, 64'h100, 0);
    // ways in use reduced, then raised again
    set_config(2, 2, 4);
    send_item(0, 64'h40, 0);
    send_item(0, 64'h80, 0);
    set_config(2, 8, 4);
    send_item(0, 64'h40, 0);
    // out of range values and the tag shift past the address
    set_config(7, 0, 63);
    send_item(0, '1, 0);
    send_item(0, 64'h5, 0);
    set_config(7, 15, 32);
    send_item(0, 64'h1234_5678_9abc_def0, 0);
    send_item(0, 64'h2234_5678_9abc_def0, 0);
    drain();
    write_cfg(2'd3, 6'h3f);   // bad register index, ignored
    send_item(0, 64'h1234_5678_9abc_def0, 0);

    // random phases over several settings
    for (int ph = 0; ph < 8; ph++) begin
      if (ph == 0) set_config(0, 1, 0);
      else if (ph == 7) set_config(6, 8, 32);
      else set_config($urandom_range(0, 7), $urandom_range(0, 15), $urandom_range(0, 63));
      foreach (addr_pool[i]) addr_pool[i] = {$urandom, $urandom};
      if (ph == 3) hold_off = 1;
      for (int n = 0; n < 125; n++) begin
        send_item(1'($urandom_range(0, 1)), pick_addr(), ph != 3);
        if (ph == 5 && n == 60) drain();
      end
    end

    drain();
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) $display("tb_top OK");
    else $display("tb_top NOT OK");
    $finish;
  end
endmodule
`default_nettype wire

/* filelist.f */
+incdir+rtl
rtl/salc_pkg.sv
rtl/salc_front.sv
rtl/salc_queue.sv
rtl/salc_back.sv
rtl/set_assoc_lru_cache_tracker.sv
test/tb_top.sv
